@@ hw/rtl/itoar_pkg.sv @@
package itoar_pkg;

    // Format codes carried on s_tuser.
    localparam logic [1:0] CMD_HEX_LOWER = 2'd0;
    localparam logic [1:0] CMD_HEX_UPPER = 2'd1;
    localparam logic [1:0] CMD_SIGNED_DEC = 2'd2;
    localparam logic [1:0] CMD_UNSIGNED_DEC = 2'd3;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;

    // Control shared by every digit cell of the chain.
    typedef struct packed {
        logic clear;  // zero the digit
        logic conv;   // one double-dabble step: adjust, then shift in one bit
        logic shift;  // take the digit of the lower neighbor
        logic dec;    // decimal adjust during conv, plain binary shift otherwise
    } cell_ctrl_t;

    function automatic logic [7:0] ascii_digit(input logic [3:0] d, input logic upper);
        logic [7:0] letter_base;
        letter_base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (d < 4'd10) begin
            return ASCII_ZERO + {4'b0000, d};
        end
        return letter_base + {4'b0000, d} - 8'd10;
    endfunction

endpackage

@@ hw/rtl/itoar_cell.sv @@
module itoar_cell (
    input  logic                   aclk,
    input  itoar_pkg::cell_ctrl_t  ctrl,
    input  logic                   bit_in,
    input  logic [3:0]             digit_in,
    output logic [3:0]             digit_out,
    output logic                   carry_out
);

    logic [3:0] digit_reg;
    logic [3:0] adjusted;

    // Add three to a decimal digit of five or more so that the doubling
    // carries into the next cell at ten.
    always_comb begin
        adjusted = digit_reg;
        if (ctrl.dec && digit_reg >= 4'd5) begin
            adjusted = digit_reg + 4'd3;
        end
    end

    assign carry_out = adjusted[3];
    assign digit_out = digit_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            digit_reg <= 4'd0;
        end else if (ctrl.conv) begin
            digit_reg <= {adjusted[2:0], bit_in};
        end else if (ctrl.shift) begin
            digit_reg <= digit_in;
        end
    end

endmodule

@@ hw/rtl/integer_to_ascii_radix.sv @@
// Integer to ASCII converter.
// Input channel: one beat carries a number and its format on s_tuser
// (0 hex lower, 1 hex upper, 2 signed decimal, 3 unsigned decimal).
// Output channel: one beat per character, most significant digit first,
// m_tlast on the final character, with the 32-bit running character count
// (including this character, wrapping) beside each character.
// The number is converted in a row of MAX_DIGITS digit cells, one
// shift-and-adjust step per cycle. Then leading zeros are dropped one at a
// time, a minus sign is sent before the digits of a negative number, and
// one character leaves per cycle while the receiver is ready.
// s_tready is high only while no number is being worked on; the next number
// can be taken while the final character still waits in the output register.
// When the receiver stalls, the held character stays and the chain waits before its next character.
// Reset clears the running count and returns the block to waiting for input.
module integer_to_ascii_radix #(
    parameter int VALUE_BITS  = 64,
    parameter int SIGNED_BITS = 32,
    parameter int MAX_DIGITS  = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // unsigned_value [63:0], signed_value [95:64]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // ch [7:0], emitted_total [39:8]
    output logic        m_tlast
);

    localparam int W  = (VALUE_BITS > SIGNED_BITS) ? VALUE_BITS : SIGNED_BITS;
    localparam int CW = $clog2(W);
    localparam int RW = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [W-1:0]  shift_reg, shift_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic          dec_reg, dec_next;
    logic          upper_reg, upper_next;
    logic          neg_reg, neg_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    ch_reg, ch_next;
    logic          last_reg, last_next;
    logic [31:0]   count_reg, count_next;

    logic                  s_accept;
    logic                  out_free;
    logic                  out_load;
    itoar_pkg::cell_ctrl_t ctrl;
    logic [3:0]            digit [MAX_DIGITS];
    logic                  carry [MAX_DIGITS];
    logic [3:0]            top_digit;
    logic                  top_carry;

    logic [63:0]            sval_ext;
    logic [SIGNED_BITS-1:0] sval;
    logic [SIGNED_BITS-1:0] smag;
    logic                   sneg;

    // The digit chain: cell 0 takes the next bit of the value, and each cell
    // passes its carry and its digit up to the next one.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                itoar_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (ctrl),
                    .bit_in    (shift_reg[W-1]),
                    .digit_in  (4'd0),
                    .digit_out (digit[gi]),
                    .carry_out (carry[gi])
                );
            end else begin : g_next
                itoar_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (ctrl),
                    .bit_in    (carry[gi-1]),
                    .digit_in  (digit[gi-1]),
                    .digit_out (digit[gi]),
                    .carry_out (carry[gi])
                );
            end
        end
    endgenerate

    // A negative number leaves the top cell for the minus sign.
    assign top_digit = neg_reg ? digit[MAX_DIGITS-2] : digit[MAX_DIGITS-1];
    assign top_carry = neg_reg ? carry[MAX_DIGITS-2] : carry[MAX_DIGITS-1];

    assign sval_ext = {{32{s_tdata[95]}}, s_tdata[95:64]};
    assign sval     = sval_ext[SIGNED_BITS-1:0];
    assign sneg     = sval[SIGNED_BITS-1];
    assign smag     = sneg ? (~sval + SIGNED_BITS'(1)) : sval;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        dec_next     = dec_reg;
        upper_next   = upper_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        ch_next      = ch_reg;
        last_next    = last_reg;
        out_load     = 1'b0;
        ctrl         = '0;
        ctrl.dec     = dec_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    ctrl.clear   = 1'b1;
                    bit_cnt_next = CW'(W - 1);
                    ovf_next     = 1'b0;
                    upper_next   = (s_tuser == itoar_pkg::CMD_HEX_UPPER);
                    if (s_tuser == itoar_pkg::CMD_SIGNED_DEC) begin
                        dec_next   = 1'b1;
                        neg_next   = sneg;
                        shift_next = W'(smag);
                    end else begin
                        dec_next   = (s_tuser == itoar_pkg::CMD_UNSIGNED_DEC);
                        neg_next   = 1'b0;
                        shift_next = W'(s_tdata[VALUE_BITS-1:0]);
                    end
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                ctrl.conv  = 1'b1;
                shift_next = shift_reg << 1;
                // A carry out of the top kept cell means more digits than fit.
                ovf_next   = ovf_reg | top_carry;
                if (bit_cnt_reg == '0) begin
                    rem_next   = neg_reg ? RW'(MAX_DIGITS - 1) : RW'(MAX_DIGITS);
                    state_next = ST_SKIP;
                end else begin
                    bit_cnt_next = bit_cnt_reg - CW'(1);
                end
            end
            ST_SKIP: begin
                if (!ovf_reg && rem_reg > RW'(1) && top_digit == 4'd0) begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - RW'(1);
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    ch_next    = itoar_pkg::ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    ch_next    = itoar_pkg::ascii_digit(top_digit, upper_reg);
                    last_next  = (rem_reg == RW'(1));
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - RW'(1);
                    if (rem_reg == RW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        count_next   = count_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            count_next   = count_reg + 32'd1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= 32'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg   <= shift_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        dec_reg     <= dec_next;
        upper_reg   <= upper_next;
        neg_reg     <= neg_next;
        ovf_reg     <= ovf_next;
        ch_reg      <= ch_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {count_reg, ch_reg};
    assign m_tlast  = last_reg;

    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> rem_reg != '0)
        else $error("emission with no digit left");

    a_sign_only_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SIGN |-> neg_reg)
        else $error("minus sign for a non-negative number");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> count_reg == $past(count_reg) + 32'd1)
        else $error("character count did not advance with a beat");

    a_decimal_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && dec_reg |-> top_digit <= 4'd9)
        else $error("decimal cell holds a digit above nine");

endmodule

@@ tb/sv/tb_integer_to_ascii_radix.sv @@
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 120;
    localparam int RANDOM_ITEMS = 410;
    localparam int DIGIT_SLOTS  = 20;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic [31:0] total;
    } char_beat_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;   // unsigned_value [63:0], signed_value [95:64]
    logic [1:0]  s_tuser  = itoar_pkg::CMD_HEX_LOWER;   // cmd [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // ch [7:0], emitted_total [39:8]
    logic        m_tlast;

    string       hex_lower_digits = "0123456789abcdef";
    string       hex_upper_digits = "0123456789ABCDEF";
    char_beat_t  pending_chars[$];
    char_beat_t  oldest_char;
    logic [31:0] char_count  = '0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          no_gaps     = 1'b0;
    bit          valid_held  = 1'b0;
    int          stall_mode  = 0;
    int          stall_left  = 0;

    integer_to_ascii_radix u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL integer_to_ascii_radix");
            $finish;
        end
    end

    // The receiver switches between always ready, coin flips, mostly ready and a
    // slow on/off rhythm, each mode held until a random countdown runs out.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= ($urandom_range(0, 9) != 0);
            end
            default: begin
                m_tready <= stall_left[2];
            end
        endcase
    end

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected beat, ch", 32'h0, {24'h0, m_tdata[7:0]});
            end else begin
                oldest_char = pending_chars.pop_front();
                if (m_tdata[7:0] !== oldest_char.ch)
                    report_mismatch("ch", {24'h0, oldest_char.ch}, {24'h0, m_tdata[7:0]});
                if (m_tlast !== oldest_char.last)
                    report_mismatch("last", {31'h0, oldest_char.last}, {31'h0, m_tlast});
                if (m_tdata[39:8] !== oldest_char.total)
                    report_mismatch("emitted_total", oldest_char.total, m_tdata[39:8]);
            end
        end
    end

    function automatic void queue_char(input logic [7:0] ch, input logic last);
        char_count = char_count + 32'd1;
        pending_chars.push_back(char_beat_t'{ch, last, char_count});
    endfunction

    // Expected characters of one number, most significant digit first.
    function automatic void predict_text(input logic [1:0] cmd, input logic [63:0] uval,
                                         input logic [31:0] sval);
        logic [63:0] mag;
        logic [63:0] radix;
        string       digits_tbl;
        bit          neg;
        int          limit;
        int          nd;
        logic [3:0]  digs[DIGIT_SLOTS];
        radix      = 64'd16;
        digits_tbl = hex_lower_digits;
        neg        = 1'b0;
        limit      = DIGIT_SLOTS;
        nd         = 0;
        case (cmd)
            itoar_pkg::CMD_SIGNED_DEC: begin
                radix = 64'd10;
                if (sval[31]) begin
                    // The 32-bit negate leaves the most negative value exact.
                    neg   = 1'b1;
                    mag   = {32'd0, -sval};
                    limit = DIGIT_SLOTS - 1;
                end else begin
                    mag = {32'd0, sval};
                end
            end
            itoar_pkg::CMD_HEX_UPPER: begin
                mag        = uval;
                digits_tbl = hex_upper_digits;
            end
            itoar_pkg::CMD_UNSIGNED_DEC: begin
                mag   = uval;
                radix = 64'd10;
            end
            default: begin
                mag = uval;
            end
        endcase
        do begin
            digs[nd] = 4'(mag % radix);
            mag      = mag / radix;
            nd++;
        end while (mag != 0 && nd < limit);
        if (neg)
            queue_char(itoar_pkg::ASCII_MINUS, 1'b0);
        for (int i = nd - 1; i >= 0; i--)
            queue_char(digits_tbl[digs[i]], i == 0);
    endfunction

    task automatic send_number(input logic [1:0] cmd, input logic [63:0] uval,
                               input logic [31:0] sval);
        int gap;
        s_tvalid   <= 1'b1;
        s_tuser    <= cmd;
        s_tdata    <= {sval, uval};
        valid_held  = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_text(cmd, uval, sval);
        if (burst_left > 0 || no_gaps) begin
            if (burst_left > 0)
                burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
            s_tvalid   <= 1'b0;
            valid_held  = 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic test_zero_each_format();
        send_number(itoar_pkg::CMD_HEX_LOWER, 64'd0, 32'd0);
        send_number(itoar_pkg::CMD_HEX_UPPER, 64'd0, 32'd0);
        send_number(itoar_pkg::CMD_SIGNED_DEC, 64'd0, 32'd0);
        send_number(itoar_pkg::CMD_UNSIGNED_DEC, 64'd0, 32'd0);
    endtask

    task automatic test_full_width();
        send_number(itoar_pkg::CMD_HEX_LOWER, {64{1'b1}}, 32'd0);
        send_number(itoar_pkg::CMD_HEX_UPPER, {64{1'b1}}, 32'd0);
        send_number(itoar_pkg::CMD_UNSIGNED_DEC, {64{1'b1}}, 32'd0);
        send_number(itoar_pkg::CMD_UNSIGNED_DEC, 64'd10000000000000000000, 32'd0);
        send_number(itoar_pkg::CMD_UNSIGNED_DEC, 64'd9, 32'd0);
        send_number(itoar_pkg::CMD_HEX_LOWER, 64'h8000_0000_0000_0000, 32'd0);
    endtask

    task automatic test_signed_extremes();
        send_number(itoar_pkg::CMD_SIGNED_DEC, 64'd0, 32'h8000_0000);
        send_number(itoar_pkg::CMD_SIGNED_DEC, 64'd0, 32'h7fff_ffff);
        send_number(itoar_pkg::CMD_SIGNED_DEC, 64'd0, 32'hffff_ffff);
        send_number(itoar_pkg::CMD_SIGNED_DEC, 64'd0, 32'd1);
        send_number(itoar_pkg::CMD_SIGNED_DEC, 64'd0, -32'sd10);
    endtask

    task automatic test_hex_letters();
        send_number(itoar_pkg::CMD_HEX_LOWER, 64'h0123_4567_89ab_cdef, 32'd0);
        send_number(itoar_pkg::CMD_HEX_UPPER, 64'hfedc_ba98_7654_3210, 32'd0);
        send_number(itoar_pkg::CMD_HEX_UPPER, 64'ha, 32'd0);
    endtask

    // The field that a format does not use must not leak into its text.
    task automatic test_unused_fields();
        send_number(itoar_pkg::CMD_SIGNED_DEC, {64{1'b1}}, 32'd42);
        send_number(itoar_pkg::CMD_HEX_LOWER, 64'h1f, 32'hffff_ffff);
        send_number(itoar_pkg::CMD_UNSIGNED_DEC, 64'd1234567890, 32'h8000_0000);
    endtask

    task automatic test_random_numbers();
        logic [1:0]  cmd;
        logic [63:0] uval;
        logic [31:0] sval;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gaps = ((n / 60) % 3 == 1);
            cmd  = 2'($urandom_range(0, 3));
            uval = {$urandom, $urandom};
            // Shorter values spread the digit counts over their whole range.
            if ($urandom_range(0, 3) != 0)
                uval = uval >> $urandom_range(0, 63);
            sval = $urandom;
            if ($urandom_range(0, 3) != 0) begin
                sval = sval >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) != 0)
                    sval = -sval;
            end
            if ($urandom_range(0, 50) == 0)
                sval = 32'h8000_0000;
            send_number(cmd, uval, sval);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_each_format();
        test_full_width();
        test_signed_extremes();
        test_hex_letters();
        test_unused_fields();
        test_random_numbers();
        if (valid_held)
            s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS integer_to_ascii_radix");
        end else begin
            $display("FAIL integer_to_ascii_radix");
        end
        $finish;
    end

endmodule
